### rtl/core/life_pkg.sv
// Shared types and constants of the life automaton row stepper.
`timescale 1ns / 1ps
`default_nettype none
package life_pkg;

    localparam int ROW_BITS = 64;
    localparam int WIDTH_BITS = 7;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT = 4'd2;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_cells;
        logic                first_row;
        logic                last_row;
    } t_in_item;

    typedef struct packed {
        logic [ROW_BITS-1:0] next_cells;
        logic                row_changed;
        logic                grid_end;
        logic                grid_changed;
    } t_out_item;

    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                changed;
    } t_row_result;

endpackage
`default_nettype wire

### rtl/core/life_rowcalc.sv
// Next generation of one row from three neighboring rows, all cells in parallel.
`timescale 1ns / 1ps
`default_nettype none
module life_rowcalc
    import life_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic [ROW_BITS-1:0]   i_up,
    input  wire logic [ROW_BITS-1:0]   i_mid,
    input  wire logic [ROW_BITS-1:0]   i_down,
    input  wire logic [WIDTH_BITS-1:0] i_width,
    output t_row_result                o_result
);

    logic [WIDTH_BITS-1:0] w_eff;
    logic [ROW_BITS-1:0]   next_bits;
    logic [ROW_BITS-1:0]   diff_bits;

    assign w_eff = (i_width > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH) : i_width;

    always_comb begin
        logic [3:0] n;
        logic       nxt;
        next_bits = '0;
        diff_bits = '0;
        for (int j = 1; j < ROW_BITS - 1; j++) begin
            n = 4'(i_up[j-1]) + 4'(i_up[j]) + 4'(i_up[j+1])
              + 4'(i_mid[j-1]) + 4'(i_mid[j+1])
              + 4'(i_down[j-1]) + 4'(i_down[j]) + 4'(i_down[j+1]);
            nxt = i_mid[j] ? ((n == KEEP_COUNT) || (n == BIRTH_COUNT)) : (n == BIRTH_COUNT);
            if (WIDTH_BITS'(j + 1) < w_eff) begin
                next_bits[j] = nxt;
                diff_bits[j] = nxt ^ i_mid[j];
            end
        end
    end

    assign o_result.cells   = next_bits;
    assign o_result.changed = |diff_bits;

endmodule
`default_nettype wire

### rtl/core/life_automaton_row_step.sv
// Top level of the B3/S23 life automaton row stepper.
`timescale 1ns / 1ps
`default_nettype none
// Takes one grid row per cycle and returns the next generation of the row
// before it; a row is accepted each cycle while the four-entry result queue
// has room for two results. A last_row row not also first_row yields two
// results (middle row, dead bottom row); results leave one per cycle unless
// stalled; an R-row grid gives R results. Boundary rows and edge columns
// come out dead; cells at or beyond row_width are zero. Write row_width
// via the configuration channel only with no rows in flight; it is not enforced.
module life_automaton_row_step
    import life_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [WIDTH_BITS-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item
);

    localparam int QDEPTH = 4;
    localparam int QPTR = $clog2(QDEPTH);

    logic [WIDTH_BITS-1:0] r_width;
    logic [ROW_BITS-1:0]   r_above, n_above;
    logic [ROW_BITS-1:0]   r_middle, n_middle;
    logic [1:0]            r_rows_seen, n_rows_seen;
    logic                  r_mid_is_top, n_mid_is_top;
    logic                  r_any, n_any;

    t_out_item             r_queue [QDEPTH];
    logic [QPTR-1:0]       r_wr_ptr, r_rd_ptr;
    logic [QPTR:0]         r_count;

    t_row_result           calc;
    t_out_item             item0, item1;
    logic [1:0]            push_n;
    logic                  accept, pop;

    life_rowcalc #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_rowcalc (
        .i_up     (r_above),
        .i_mid    (r_middle),
        .i_down   (i_in_item.row_cells),
        .i_width  (r_width),
        .o_result (calc)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_count > (QPTR+1)'(QDEPTH - 2);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_count != '0;
    assign o_out_item  = r_queue[r_rd_ptr];
    assign pop         = o_out_valid && !i_out_stall;

    always_comb begin
        logic ch;
        n_above      = r_above;
        n_middle     = r_middle;
        n_rows_seen  = r_rows_seen;
        n_mid_is_top = r_mid_is_top;
        n_any        = r_any;
        item0        = '0;
        item1        = '0;
        push_n       = 2'd0;
        ch           = calc.changed && !r_mid_is_top;
        if (accept) begin
            if (i_in_item.first_row) begin
                n_any   = 1'b0;
                n_above = '0;
                if (i_in_item.last_row) begin
                    item0.grid_end = 1'b1;
                    push_n         = 2'd1;
                    n_rows_seen    = 2'd0;
                    n_mid_is_top   = 1'b0;
                    n_middle       = '0;
                end else begin
                    n_middle     = i_in_item.row_cells;
                    n_rows_seen  = 2'd1;
                    n_mid_is_top = 1'b1;
                end
            end else if (r_rows_seen != 2'd0) begin
                n_any             = r_any | ch;
                item0.next_cells  = r_mid_is_top ? '0 : calc.cells;
                item0.row_changed = ch;
                if (i_in_item.last_row) begin
                    item1.grid_end     = 1'b1;
                    item1.grid_changed = n_any;
                    push_n             = 2'd2;
                    n_rows_seen        = 2'd0;
                    n_mid_is_top       = 1'b0;
                end else begin
                    push_n       = 2'd1;
                    n_above      = r_middle;
                    n_middle     = i_in_item.row_cells;
                    n_rows_seen  = 2'd2;
                    n_mid_is_top = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WIDTH_RESET;
            r_above      <= '0;
            r_middle     <= '0;
            r_rows_seen  <= 2'd0;
            r_mid_is_top <= 1'b0;
            r_any        <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_width <= i_cfg_data;
            end
            r_above      <= n_above;
            r_middle     <= n_middle;
            r_rows_seen  <= n_rows_seen;
            r_mid_is_top <= n_mid_is_top;
            r_any        <= n_any;
            r_wr_ptr     <= r_wr_ptr + QPTR'(push_n);
            r_rd_ptr     <= r_rd_ptr + QPTR'(pop);
            r_count      <= r_count + (QPTR+1)'(push_n) - (QPTR+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= item0;
        end
        if (push_n == 2'd2) begin
            r_queue[r_wr_ptr + QPTR'(1)] <= item1;
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR+1)'(QDEPTH))
        else $error("result queue overflow");

    a_top_only_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_is_top |-> r_rows_seen == 2'd1)
        else $error("top row flag without single held row");

    a_start_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_item.first_row && !i_in_item.last_row
        |=> r_rows_seen == 2'd1 && r_mid_is_top && !r_any)
        else $error("new grid not started");

    a_end_row_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.grid_end || o_out_item.grid_changed)
        |-> o_out_item.grid_end && o_out_item.next_cells == '0
            && !o_out_item.row_changed)
        else $error("bad grid end transaction");

endmodule
`default_nettype wire
